/* hw/rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, constants and the digit decoder of the radix numeral parser.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 8;
    localparam int PROD_WIDTH  = VALUE_WIDTH + RADIX_WIDTH;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(36);
    localparam logic [RADIX_WIDTH-1:0] NO_DIGIT    = RADIX_WIDTH'(36);

    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [PROD_WIDTH-1:0]  t_prod;
    typedef logic [RADIX_WIDTH-1:0] t_digit;

    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_MINUS = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind  kind;
        t_digit digit;
        t_digit radix;
        logic   last;
    } t_entry;

    function automatic t_digit digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] d;
        begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                d = c - CH_LO_A + 8'd10;
            end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                d = c - CH_UP_A + 8'd10;
            end else begin
                d = CHAR_WIDTH'(NO_DIGIT);
            end
            return d[RADIX_WIDTH-1:0];
        end
    endfunction

endpackage

/* hw/rtl/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front
// Accepts characters, tracks the numeral start and classifies each beat.
// ----------------------------------------------------------------------------
module rsi_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rsi_pkg::CHAR_WIDTH-1:0]  i_char_code,
    input  logic                            i_end_of_text,
    input  logic [rsi_pkg::RADIX_WIDTH-1:0] i_radix,
    input  logic                            i_q_full,
    output logic                            o_push,
    output rsi_pkg::t_entry                 o_entry
);
    import rsi_pkg::*;

    logic   r_at_start;
    logic   n_at_start;
    logic   accept;
    t_digit dig;
    logic   radix_ok;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    assign dig      = digit_of(i_char_code);
    assign radix_ok = (i_radix >= RADIX_MIN) && (i_radix <= RADIX_MAX);

    always_comb begin
        o_entry.digit = dig;
        o_entry.radix = i_radix;
        o_entry.last  = i_end_of_text;
        if (r_at_start && i_char_code < CH_ZERO) begin
            o_entry.kind = (i_char_code == CH_MINUS) ? KIND_MINUS : KIND_BAD;
        end else if (!radix_ok || dig >= i_radix) begin
            o_entry.kind = KIND_BAD;
        end else begin
            o_entry.kind = KIND_DIGIT;
        end
    end

    always_comb begin
        n_at_start = r_at_start;
        if (accept) begin
            n_at_start = i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

endmodule

/* hw/rtl/rsi_queue.sv */
// ----------------------------------------------------------------------------
// rsi_queue
// Two-entry queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module rsi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsi_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output rsi_pkg::t_entry o_entry
);
    import rsi_pkg::*;

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_wptr  = r_wptr ^ do_push;
        n_rptr  = r_rptr ^ do_pop;
        n_count = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

/* hw/rtl/rsi_back.sv */
// ----------------------------------------------------------------------------
// rsi_back
// Accumulates digits with overflow check and emits one result per numeral.
// ----------------------------------------------------------------------------
module rsi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  rsi_pkg::t_entry               i_entry,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rsi_pkg::OUT_WIDTH-1:0] o_parsed_value,
    output logic [1:0]                    o_status
);
    import rsi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_value r_acc, n_acc;
    logic   r_neg, n_neg;
    logic   r_sign_only, n_sign_only;
    logic   [1:0] r_err, n_err;
    t_prod  r_prod, n_prod;
    t_digit r_digit, n_digit;
    logic   r_last, n_last;
    logic   r_ov, n_ov;
    logic   [OUT_WIDTH-1:0] r_val, n_val;
    logic   [1:0] r_st, n_st;

    logic   slot_free;
    t_prod  sum;
    t_prod  lim;
    logic   [1:0] fin_st;
    t_value mag;

    assign slot_free      = !r_ov || !i_out_stall;
    assign o_out_valid    = r_ov;
    assign o_parsed_value = r_val;
    assign o_status       = r_st;

    assign sum = r_prod + PROD_WIDTH'(r_digit);
    assign lim = (t_prod'(1) << (VALUE_WIDTH - 1)) - PROD_WIDTH'(!r_neg);
    assign fin_st = (r_err == ST_OK && r_sign_only) ? ST_BAD : r_err;
    assign mag = r_neg ? (~r_acc + t_value'(1)) : r_acc;

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_sign_only = r_sign_only;
        n_err       = r_err;
        n_prod      = r_prod;
        n_digit     = r_digit;
        n_last      = r_last;
        n_ov        = r_ov && i_out_stall;
        n_val       = r_val;
        n_st        = r_st;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (r_err == ST_OK && i_entry.kind == KIND_DIGIT) begin
                        n_prod  = t_prod'(r_acc) * t_prod'(i_entry.radix);
                        n_digit = i_entry.digit;
                        n_last  = i_entry.last;
                        n_state = S_ADD;
                    end else begin
                        if (r_err == ST_OK) begin
                            if (i_entry.kind == KIND_MINUS) begin
                                n_neg       = 1'b1;
                                n_sign_only = 1'b1;
                            end else begin
                                n_err = ST_BAD;
                            end
                        end
                        if (i_entry.last) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_ADD: begin
                if (sum > lim) begin
                    n_err = ST_OVF;
                end else begin
                    n_acc       = sum[VALUE_WIDTH-1:0];
                    n_sign_only = 1'b0;
                end
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (slot_free) begin
                    n_ov        = 1'b1;
                    n_st        = fin_st;
                    n_val       = (fin_st == ST_OK) ? OUT_WIDTH'($signed(mag)) : '0;
                    n_acc       = '0;
                    n_neg       = 1'b0;
                    n_sign_only = 1'b0;
                    n_err       = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_sign_only <= 1'b0;
            r_err       <= ST_OK;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_sign_only <= n_sign_only;
            r_err       <= n_err;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_digit <= n_digit;
        r_last  <= n_last;
        r_val   <= n_val;
        r_st    <= n_st;
    end

endmodule

/* hw/rtl/radix_string_to_int64.sv */
// ----------------------------------------------------------------------------
// radix_string_to_int64
// Parses a stream of numeral characters into a signed 64-bit value with
// status, one result per numeral.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | beat
//  input    | in        | i_in_valid / o_in_stall   | i_char_code, i_end_of_text
//  output   | out       | o_out_valid / i_out_stall | o_parsed_value, o_status
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_radix
//
//  a digit beat runs in the back end as a registered multiply of the
//  accumulator by the radix, then the add of the digit and the limit compare
//  sign, bad and ignored beats are handled in the idle state alone; the last
//  beat adds a pass through the finish state to load the output register
//  a two-entry queue lets the front keep taking beats while the back works
//  synchronous active-low reset; radix resets to 10, no clearing pass
// ----------------------------------------------------------------------------
module radix_string_to_int64 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rsi_pkg::CHAR_WIDTH-1:0]  i_char_code,
    input  logic                            i_end_of_text,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rsi_pkg::OUT_WIDTH-1:0]   o_parsed_value,
    output logic [1:0]                      o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsi_pkg::RADIX_WIDTH-1:0] i_cfg_radix
);
    import rsi_pkg::*;

    t_digit r_radix;
    t_entry front_entry;
    t_entry queue_entry;
    logic   push;
    logic   q_full;
    logic   q_avail;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_radix;
        end
    end

    rsi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_radix       (r_radix),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    rsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_entry (queue_entry)
    );

    rsi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_entry        (queue_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_parsed_value (o_parsed_value),
        .o_status       (o_status)
    );

endmodule

/* sim/radix_string_to_int64_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_string_to_int64_check
// Watches the character, result and radix channels of the numeral parser.
// Every accepted character beat runs through a local copy of the parser.
// Each finished numeral queues the value and status it should produce.
// Every accepted result beat is compared with the oldest queued numeral.
// ----------------------------------------------------------------------------
module radix_string_to_int64_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [rsi_pkg::CHAR_WIDTH-1:0]  i_char_code,
    input  logic                            i_end_of_text,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [rsi_pkg::OUT_WIDTH-1:0]   i_parsed_value,
    input  logic [1:0]                      i_status,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [rsi_pkg::RADIX_WIDTH-1:0] i_cfg_radix,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_checked
);
    import rsi_pkg::*;

    localparam int PRINT_CAP = 20;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic [1:0]           status;
    } t_numeral;

    t_numeral numerals_due[$];

    t_value                 magnitude;
    logic                   negative;
    logic                   first_char;
    logic                   sign_seen_only;
    logic [1:0]             fault;
    logic [RADIX_WIDTH-1:0] radix;
    int                     mismatch_count = 0;
    int                     checked_count  = 0;

    function automatic void clear_numeral();
        magnitude      = '0;
        negative       = 1'b0;
        first_char     = 1'b1;
        sign_seen_only = 1'b0;
        fault          = ST_OK;
    endfunction

    function automatic void parse_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
        logic [63:0] d;
        logic [63:0] lim;
        logic [63:0] rad;
        logic [63:0] prod;
        t_numeral    due;
        if (fault == ST_OK) begin
            if (first_char && c < CH_ZERO) begin
                if (c == CH_MINUS) begin
                    negative       = 1'b1;
                    sign_seen_only = 1'b1;
                end else begin
                    fault = ST_BAD;
                end
            end else begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    d = 64'(c) - 64'(CH_ZERO);
                end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                    d = 64'(c) - 64'(CH_LO_A) + 64'd10;
                end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                    d = 64'(c) - 64'(CH_UP_A) + 64'd10;
                end else begin
                    d = 64'(NO_DIGIT);
                end
                lim = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                rad = 64'(radix);
                if (rad < 64'(RADIX_MIN) || rad > 64'(RADIX_MAX) || d >= rad) begin
                    fault = ST_BAD;
                end else if (magnitude > lim / rad) begin
                    fault = ST_OVF;
                end else begin
                    prod = magnitude * rad;
                    if (prod > lim - d) begin
                        fault = ST_OVF;
                    end else begin
                        magnitude      = prod + d;
                        sign_seen_only = 1'b0;
                    end
                end
            end
        end
        first_char = 1'b0;
        if (last) begin
            // a sign with no digit after it
            if (fault == ST_OK && sign_seen_only) begin
                fault = ST_BAD;
            end
            if (fault == ST_OK) begin
                due.value = negative ? (~magnitude + 64'd1) : magnitude;
            end else begin
                due.value = '0;
            end
            due.status = fault;
            numerals_due.push_back(due);
            clear_numeral();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_numeral due;
        if (!i_rst_n) begin
            numerals_due.delete();
            radix = RADIX_RESET;
            clear_numeral();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                radix = i_cfg_radix;
            end
            if (i_out_valid && !i_out_stall) begin
                if (numerals_due.size() == 0) begin
                    report_mismatch("result beat with nothing due", i_parsed_value,
                                    64'(i_status));
                end else begin
                    due = numerals_due.pop_front();
                    checked_count++;
                    if (i_parsed_value !== due.value) begin
                        report_mismatch("parsed_value", i_parsed_value, due.value);
                    end
                    if (i_status !== due.status) begin
                        report_mismatch("status", 64'(i_status), 64'(due.status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_char_code, i_end_of_text);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= numerals_due.size();
        o_checked    <= checked_count;
    end

endmodule

/* sim/radix_string_to_int64_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_string_to_int64_test
// Drives numerals into the radix parser and gives the verdict.
// A short directed part covers sign forms, bad digits, radix edges and a
// radix change inside a numeral. Random phases follow under many radix
// settings, in range and out of it. Most numerals are well formed, many
// of them near the signed limits, and the rest are broken or noise.
// Both sides idle at random, and the receiver holds off once at length.
// ----------------------------------------------------------------------------
module radix_string_to_int64_test;
    import rsi_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 210;
    localparam int ODD_ITEMS    = 30;
    localparam int RADIX_PICK   = -1;
    localparam int PHASE_CALM   = 3;
    localparam int PHASE_HOLD   = 4;
    localparam int PHASE_PAUSE  = 7;
    localparam int PHASE_COUNT  = 13;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic [CHAR_WIDTH-1:0]  i_char_code   = '0;
    logic                   i_end_of_text = 1'b0;
    logic                   i_out_stall   = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [RADIX_WIDTH-1:0] i_cfg_radix   = RADIX_RESET;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [OUT_WIDTH-1:0]   o_parsed_value;
    logic [1:0]             o_status;
    logic                   o_cfg_ready;

    int fail_count;
    int pending_count;
    int checked_count;

    int cycle_count   = 0;
    int chars_sent    = 0;
    int numerals_sent = 0;
    int radix_writes  = 0;
    int stall_left    = 0;
    int hold_req      = 0;
    int hold_done     = 0;
    bit calm_send     = 1'b0;
    bit calm_recv     = 1'b0;

    logic [RADIX_WIDTH-1:0] cur_radix = RADIX_RESET;
    logic [CHAR_WIDTH-1:0]  text_buf[$];
    int phase_radix[PHASE_COUNT] = '{10, 2, 0, 36, 16, 37, RADIX_PICK, 8, 1,
                                     RADIX_PICK, 63, 36, 10};

    radix_string_to_int64 uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_parsed_value (o_parsed_value),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_radix    (i_cfg_radix)
    );

    radix_string_to_int64_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_end_of_text  (i_end_of_text),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_parsed_value (o_parsed_value),
        .i_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_radix    (i_cfg_radix),
        .o_mismatches   (fail_count),
        .o_pending      (pending_count),
        .o_checked      (checked_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d numerals still due", pending_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done  = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm_recv || $urandom_range(0, 99) < 80) begin
                i_out_stall <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
                stall_left--;
                i_out_stall <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_send || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input int d);
        if (d < 10) begin
            return CHAR_WIDTH'(int'(CH_ZERO) + d);
        end
        if ($urandom_range(0, 1) == 1) begin
            return CHAR_WIDTH'(int'(CH_LO_A) + d - 10);
        end
        return CHAR_WIDTH'(int'(CH_UP_A) + d - 10);
    endfunction

    function automatic logic [63:0] pick_magnitude();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 64'($urandom_range(0, 999));
        end else if (r < 7) begin
            return {$urandom, $urandom} >> $urandom_range(0, 63);
        end else if (r < 9) begin
            // around the positive limit and the negative limit
            return 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 3)) - 64'd1;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
        int gap;
        i_in_valid    <= 1'b1;
        i_char_code   <= c;
        i_end_of_text <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        chars_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_WIDTH-1:0] r);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_radix <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_radix = r;
        radix_writes++;
    endtask

    task automatic build_number(input logic [63:0] mag, input bit neg);
        logic [63:0]           m;
        logic [CHAR_WIDTH-1:0] digits[$];
        int                    zeros;
        m = mag;
        do begin
            digits.push_front(digit_char(int'(m % 64'(cur_radix))));
            m = m / 64'(cur_radix);
        end while (m != 0);
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        text_buf.delete();
        if (neg) begin
            text_buf.push_back(CH_MINUS);
        end
        repeat (zeros) text_buf.push_back(CH_ZERO);
        foreach (digits[k]) text_buf.push_back(digits[k]);
    endtask

    task automatic random_numeral();
        int pick;
        int pos;
        bit neg;
        pick = $urandom_range(0, 99);
        neg  = $urandom_range(0, 1);
        if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX) begin
            text_buf.delete();
            if (neg) begin
                text_buf.push_back(CH_MINUS);
            end
            repeat ($urandom_range(1, 4)) text_buf.push_back(digit_char($urandom_range(0, 35)));
        end else if (pick < 70) begin
            build_number(pick_magnitude(), neg);
        end else if (pick < 80) begin
            // sign forms: lone minus, junk first char, minus then digits
            text_buf.delete();
            if (neg) begin
                text_buf.push_back(CH_MINUS);
            end else begin
                text_buf.push_back(CHAR_WIDTH'($urandom_range(0, int'(CH_ZERO) - 1)));
            end
            repeat ($urandom_range(0, 3)) begin
                text_buf.push_back(digit_char($urandom_range(0, int'(cur_radix) - 1)));
            end
        end else if (pick < 90) begin
            build_number(64'($urandom_range(0, 99999)), neg);
            pos = $urandom_range(0, text_buf.size() - 1);
            text_buf[pos] = CHAR_WIDTH'($urandom_range(0, 255));
        end else begin
            text_buf.delete();
            repeat ($urandom_range(1, 6)) text_buf.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        end
        foreach (text_buf[k]) send_char(text_buf[k], k == text_buf.size() - 1);
        numerals_sent++;
    endtask

    initial begin : stimulus
        int p;
        int phase_end;
        int r;
        bit paused;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset radix
        send_char(CH_ZERO, 1'b1);
        send_char(CH_MINUS, 1'b1);
        send_char("+", 1'b0);
        send_char("7", 1'b1);
        send_char(CH_MINUS, 1'b0);
        send_char(CH_NINE, 1'b1);
        send_char("1", 1'b0);
        send_char("a", 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(CH_MINUS, 1'b0);
        send_char("x", 1'b0);
        send_char(CH_MINUS, 1'b1);
        // radix change between two digits of one numeral
        send_char("1", 1'b0);
        write_radix(RADIX_MAX);
        send_char("Z", 1'b1);
        send_char("z", 1'b1);
        write_radix(RADIX_MIN);
        send_char("1", 1'b0);
        send_char("0", 1'b0);
        send_char("1", 1'b1);
        write_radix('0);
        send_char(CH_ZERO, 1'b1);
        numerals_sent += 12;

        for (p = 0; p < PHASE_COUNT; p++) begin
            r = (phase_radix[p] == RADIX_PICK) ? $urandom_range(3, 35) : phase_radix[p];
            write_radix(RADIX_WIDTH'(r));
            calm_send = (p == PHASE_CALM) || (p == PHASE_HOLD);
            calm_recv = (p == PHASE_CALM);
            if (p == PHASE_HOLD) begin
                hold_req++;
            end
            paused = 1'b0;
            phase_end = chars_sent +
                ((cur_radix >= RADIX_MIN && cur_radix <= RADIX_MAX) ? PHASE_ITEMS : ODD_ITEMS);
            while (chars_sent < phase_end) begin
                if (p == PHASE_PAUSE && !paused && chars_sent >= phase_end - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_numeral();
            end
            calm_send = 1'b0;
            calm_recv = 1'b0;
        end

        wait_drained();
        $display("%0d numerals in %0d characters sent, %0d results compared",
                 numerals_sent, chars_sent, checked_count);
        $display("%0d radix writes over both ends of the range and out-of-range bases",
                 radix_writes);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
